// ===== design/pcg8_pkg.sv =====
package pcg8_pkg;

  // lane count and derived widths
  localparam int LANES = 8;
  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W = $clog2(LANES + 1);

  // generator constants
  localparam logic [63:0] PCG_MULT          = 64'd6364136223846793005;
  localparam logic [63:0] PCG_STATE_DEFAULT = 64'h853c49e6748fea9b;
  localparam logic [63:0] PCG_INC_DEFAULT   = 64'hda3e39cb94b95bdb;

  // command codes
  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // multiplier raised to the lane count
  function automatic logic [63:0] jump_mult_f();
    logic [63:0] m;
    m = 64'd1;
    for (int i = 0; i < LANES; i++) begin
      m = m * PCG_MULT;
    end
    return m;
  endfunction

  // sum of multiplier powers below the lane count, scales the increment
  function automatic logic [63:0] jump_sum_f();
    logic [63:0] s;
    logic [63:0] p;
    s = 64'd0;
    p = 64'd1;
    for (int i = 0; i < LANES; i++) begin
      s = s + p;
      p = p * PCG_MULT;
    end
    return s;
  endfunction

  localparam logic [63:0] JUMP_MULT = jump_mult_f();
  localparam logic [63:0] JUMP_SUM  = jump_sum_f();

  // xsh-rr output permutation
  function automatic logic [31:0] pcg_output(input logic [63:0] s);
    logic [31:0] xs;
    logic [4:0]  rot;
    xs  = 32'(((s >> 18) ^ s) >> 27);
    rot = s[63:59];
    return (xs >> rot) | (xs << ((~rot) + 5'd1));
  endfunction

  typedef struct packed {
    logic       func;
    logic [3:0] count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] rand_word;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_START,
    ST_SEED_WAIT,
    ST_JINC_START,
    ST_JINC_WAIT,
    ST_EMIT,
    ST_JUMP_START,
    ST_JUMP_WAIT
  } state_t;

  typedef enum logic [1:0] {
    MAC_FILL,
    MAC_JINC,
    MAC_JUMP
  } mac_sel_t;

  typedef struct packed {
    logic             seed_load;
    logic             mac_start;
    mac_sel_t         mac_sel;
    logic             lane_wr;
    logic             jinc_wr;
    logic             emit;
    logic             emit_last;
    logic [IDX_W-1:0] lane_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mac_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/pcg32_eight_lane_generator_top.sv =====
// draw: the first word passes through the EMIT state and the output register after the
//   beat is taken, then one word per cycle while out_ready is high; afterwards every lane
//   is advanced by one 64-bit multiply-add on a shared 32x32 multiplier (four passes per
//   lane), and in_ready returns once the last lane is written
// reseed: lane fill plus jump increment, no output words
// reset: lanes zero, increment one, identity jump, sequence register zero
module pcg32_eight_lane_generator_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcg8_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pcg8_pkg::out_item_t  out_item,
  input  logic                 cfg_we,
  input  logic [63:0]          cfg_wdata
);

  pcg8_pkg::ctrl_cmd_t cmd;
  pcg8_pkg::dp_stat_t  stat;

  // sequencer
  pcg8_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat)
  );

  // lanes, multiply-add unit and output register
  pcg8_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== design/pcg8_mac.sv =====
module pcg8_mac (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] c,
  output logic        done,
  output logic [63:0] result
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [1:0]  step;
  logic        busy;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // one shared 32x32 multiplier: lo*lo, lo*hi, hi*lo
  always_comb begin
    mul_a = (step == 2'd2) ? a_r[63:32] : a_r[31:0];
    mul_b = (step == 2'd1) ? b_r[63:32] : b_r[31:0];
  end

  assign mul_p = mul_a * mul_b;

  // control of the four-pass multiply-add
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial product accumulation, result kept mod 2^64
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      acc <= c;
    end else if (busy) begin
      prod <= mul_p;
      case (step)
        2'd1:    acc <= acc + prod;
        2'd2:    acc <= acc + {prod[31:0], 32'd0};
        2'd3:    acc <= acc + {prod[31:0], 32'd0};
        default: acc <= acc;
      endcase
    end
  end

  assign result = acc;

  // a new operation never starts on top of a running one
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("mac started while busy");

  // completion is a single-cycle pulse after the last pass
  assert property (@(posedge clk) disable iff (rst) done |=> !done && !busy)
    else $error("mac done not a single pulse");

endmodule

// ===== design/pcg8_dp.sv =====
module pcg8_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  pcg8_pkg::ctrl_cmd_t   cmd,
  output pcg8_pkg::dp_stat_t    stat,
  input  logic                  cfg_we,
  input  logic [63:0]           cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pcg8_pkg::out_item_t   out_item
);

  logic [63:0] seed_sequence;
  logic [63:0] lane_state [pcg8_pkg::LANES];
  logic [63:0] lane_increment;
  logic [63:0] jump_multiplier;
  logic [63:0] jump_increment;
  logic [63:0] seed_s;
  logic [63:0] seq_sel;
  logic [63:0] init_sel;
  logic [63:0] inc_new;
  logic [63:0] mac_a;
  logic [63:0] mac_b;
  logic [63:0] mac_c;
  logic        mac_done;
  logic [63:0] mac_result;

  // increment and start state from the sequence register
  always_comb begin
    seq_sel  = (seed_sequence == 64'd0) ? pcg8_pkg::PCG_INC_DEFAULT : seed_sequence;
    init_sel = pcg8_pkg::PCG_STATE_DEFAULT ^ seed_sequence;
    if (init_sel == 64'd0) begin
      init_sel = pcg8_pkg::PCG_STATE_DEFAULT;
    end
    inc_new = {seq_sel[62:0], 1'b1};
  end

  // multiply-add operand select
  always_comb begin
    unique case (cmd.mac_sel)
      pcg8_pkg::MAC_FILL: begin
        mac_a = seed_s;
        mac_b = pcg8_pkg::PCG_MULT;
        mac_c = lane_increment;
      end
      pcg8_pkg::MAC_JINC: begin
        mac_a = lane_increment;
        mac_b = pcg8_pkg::JUMP_SUM;
        mac_c = 64'd0;
      end
      pcg8_pkg::MAC_JUMP: begin
        mac_a = lane_state[cmd.lane_idx];
        mac_b = jump_multiplier;
        mac_c = jump_increment;
      end
      default: begin
        mac_a = 64'd0;
        mac_b = 64'd0;
        mac_c = 64'd0;
      end
    endcase
  end

  pcg8_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mac_start),
    .a      (mac_a),
    .b      (mac_b),
    .c      (mac_c),
    .done   (mac_done),
    .result (mac_result)
  );

  // generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_sequence   <= 64'd0;
      lane_increment  <= 64'd1;
      jump_multiplier <= 64'd1;
      jump_increment  <= 64'd0;
      for (int i = 0; i < pcg8_pkg::LANES; i++) begin
        lane_state[i] <= 64'd0;
      end
    end else begin
      if (cfg_we) begin
        seed_sequence <= cfg_wdata;
      end
      if (cmd.seed_load) begin
        lane_increment <= inc_new;
      end
      if (cmd.lane_wr) begin
        lane_state[cmd.lane_idx] <= mac_result;
      end
      if (cmd.jinc_wr) begin
        jump_multiplier <= pcg8_pkg::JUMP_MULT;
        jump_increment  <= mac_result;
      end
    end
  end

  // running seed value during the lane fill
  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      seed_s <= inc_new + init_sel;
    end else if (cmd.lane_wr) begin
      seed_s <= mac_result;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.rand_word <= pcg8_pkg::pcg_output(lane_state[cmd.lane_idx]);
      out_item.last      <= cmd.emit_last;
    end
  end

  assign stat.mac_done = mac_done;
  assign stat.out_free = !out_valid || out_ready;

endmodule

// ===== design/pcg8_ctrl.sv =====
module pcg8_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pcg8_pkg::in_item_t   in_item,
  output pcg8_pkg::ctrl_cmd_t  cmd,
  input  pcg8_pkg::dp_stat_t   stat
);

  pcg8_pkg::state_t               state;
  pcg8_pkg::state_t               state_next;
  logic [pcg8_pkg::IDX_W-1:0]     idx;
  logic [pcg8_pkg::IDX_W-1:0]     idx_next;
  logic [pcg8_pkg::CNT_W-1:0]     num;
  logic [pcg8_pkg::CNT_W-1:0]     num_next;
  logic [pcg8_pkg::CNT_W-1:0]     count_sat;
  logic                           idx_at_end;
  logic                           idx_at_num;

  // requested word count, saturated to the lane count
  always_comb begin
    count_sat = (int'(in_item.count) > pcg8_pkg::LANES) ?
                pcg8_pkg::CNT_W'(pcg8_pkg::LANES) : pcg8_pkg::CNT_W'(in_item.count);
    idx_at_end = (idx == pcg8_pkg::IDX_W'(pcg8_pkg::LANES - 1));
    idx_at_num = ((pcg8_pkg::CNT_W'(idx) + pcg8_pkg::CNT_W'(1)) == num);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcg8_pkg::ST_IDLE;
      idx   <= '0;
      num   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      num   <= num_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    num_next      = num;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mac_sel   = pcg8_pkg::MAC_FILL;
    cmd.lane_idx  = idx;
    unique case (state)
      pcg8_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        idx_next = '0;
        if (in_valid) begin
          if (in_item.func == pcg8_pkg::FUNC_SEED) begin
            cmd.seed_load = 1'b1;
            state_next    = pcg8_pkg::ST_SEED_START;
          end else if (count_sat != '0) begin
            num_next   = count_sat;
            state_next = pcg8_pkg::ST_EMIT;
          end
        end
      end
      pcg8_pkg::ST_SEED_START: begin
        cmd.mac_start = 1'b1;
        cmd.mac_sel   = pcg8_pkg::MAC_FILL;
        state_next    = pcg8_pkg::ST_SEED_WAIT;
      end
      pcg8_pkg::ST_SEED_WAIT: begin
        cmd.mac_sel = pcg8_pkg::MAC_FILL;
        if (stat.mac_done) begin
          cmd.lane_wr = 1'b1;
          if (idx_at_end) begin
            idx_next   = '0;
            state_next = pcg8_pkg::ST_JINC_START;
          end else begin
            idx_next   = idx + pcg8_pkg::IDX_W'(1);
            state_next = pcg8_pkg::ST_SEED_START;
          end
        end
      end
      pcg8_pkg::ST_JINC_START: begin
        cmd.mac_start = 1'b1;
        cmd.mac_sel   = pcg8_pkg::MAC_JINC;
        state_next    = pcg8_pkg::ST_JINC_WAIT;
      end
      pcg8_pkg::ST_JINC_WAIT: begin
        cmd.mac_sel = pcg8_pkg::MAC_JINC;
        if (stat.mac_done) begin
          cmd.jinc_wr = 1'b1;
          state_next  = pcg8_pkg::ST_IDLE;
        end
      end
      pcg8_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = idx_at_num;
          if (idx_at_num) begin
            idx_next   = '0;
            state_next = pcg8_pkg::ST_JUMP_START;
          end else begin
            idx_next = idx + pcg8_pkg::IDX_W'(1);
          end
        end
      end
      pcg8_pkg::ST_JUMP_START: begin
        cmd.mac_start = 1'b1;
        cmd.mac_sel   = pcg8_pkg::MAC_JUMP;
        state_next    = pcg8_pkg::ST_JUMP_WAIT;
      end
      pcg8_pkg::ST_JUMP_WAIT: begin
        cmd.mac_sel = pcg8_pkg::MAC_JUMP;
        if (stat.mac_done) begin
          cmd.lane_wr = 1'b1;
          if (idx_at_end) begin
            idx_next   = '0;
            state_next = pcg8_pkg::ST_IDLE;
          end else begin
            idx_next   = idx + pcg8_pkg::IDX_W'(1);
            state_next = pcg8_pkg::ST_JUMP_START;
          end
        end
      end
      default: begin
        state_next = pcg8_pkg::ST_IDLE;
      end
    endcase
  end

  // multiply-add completions only arrive while a wait state expects them
  assert property (@(posedge clk) disable iff (rst)
    stat.mac_done |-> (state == pcg8_pkg::ST_SEED_WAIT ||
                       state == pcg8_pkg::ST_JINC_WAIT ||
                       state == pcg8_pkg::ST_JUMP_WAIT))
    else $error("mac completion outside a wait state");

  // a word is only produced when the output register can take it
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> stat.out_free)
    else $error("word emitted into a full output register");

  // the flagged word of a draw always leads into the lane jump
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.emit_last |=> state == pcg8_pkg::ST_JUMP_START && idx == '0)
    else $error("last word not followed by lane jump");

endmodule
